FILE: sv/tccw_pkg.sv
// shared types, constants and the microcode table of the text console character writer
package tccw_pkg;

  // screen geometry
  localparam int unsigned COLS  = 80;
  localparam int unsigned ROWS  = 25;
  localparam int unsigned CELLS = COLS * ROWS;

  // field widths
  localparam int unsigned COL_W     = 7;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned ADDR_W    = 11;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [DATA_W-1:0] cell_data;
    logic              scrolled;
  } result_t;

  // microprogram steps
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT_CHECK,
    ST_COPY,
    ST_COPY_TAIL,
    ST_FILL,
    ST_PUT_DONE,
    ST_READ,
    ST_READ_DONE
  } step_e;

  typedef enum logic [1:0] {
    WE_NONE,
    WE_ALWAYS,
    WE_PRINT,
    WE_CNT_NZ
  } we_sel_e;

  typedef enum logic [1:0] {
    WADDR_CNT,
    WADDR_CNT_M1,
    WADDR_CURSOR
  } waddr_sel_e;

  typedef enum logic {
    RADDR_CNT_COLS,
    RADDR_INDEX
  } raddr_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_CHAR,
    WD_RDATA,
    WD_BLANK
  } wdata_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_LAST,
    COND_NOT_COPY_END,
    COND_NO_START,
    COND_IS_READ,
    COND_NO_SCROLL
  } cond_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PUT,
    EMIT_READ
  } emit_e;

  typedef struct packed {
    logic       idle;
    we_sel_e    we_sel;
    waddr_sel_e waddr_sel;
    raddr_sel_e raddr_sel;
    wdata_sel_e wdata_sel;
    cnt_op_e    cnt_op;
    logic       cur_upd;
    emit_e      emit;
    cond_e      cond;
    step_e      target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    idle:      1'b0,
    we_sel:    WE_NONE,
    waddr_sel: WADDR_CNT,
    raddr_sel: RADDR_CNT_COLS,
    wdata_sel: WD_ZERO,
    cnt_op:    CNT_HOLD,
    cur_upd:   1'b0,
    emit:      EMIT_NONE,
    cond:      COND_NEVER,
    target:    ST_IDLE
  };

  // control word of each step; a jump is taken when its condition holds
  function automatic ctrl_t ucode(step_e step);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (step)
      ST_CLEAR: begin
        c.we_sel    = WE_ALWAYS;
        c.waddr_sel = WADDR_CNT;
        c.wdata_sel = WD_ZERO;
        c.cnt_op    = CNT_INC;
        c.cond      = COND_NOT_LAST;
        c.target    = ST_CLEAR;
      end
      ST_IDLE: begin
        c.idle   = 1'b1;
        c.cnt_op = CNT_CLEAR;
        c.cond   = COND_NO_START;
        c.target = ST_IDLE;
      end
      ST_DISPATCH: begin
        c.we_sel    = WE_PRINT;
        c.waddr_sel = WADDR_CURSOR;
        c.wdata_sel = WD_CHAR;
        c.cur_upd   = 1'b1;
        c.cond      = COND_IS_READ;
        c.target    = ST_READ;
      end
      ST_PUT_CHECK: begin
        c.cond   = COND_NO_SCROLL;
        c.target = ST_PUT_DONE;
      end
      ST_COPY: begin
        c.raddr_sel = RADDR_CNT_COLS;
        c.we_sel    = WE_CNT_NZ;
        c.waddr_sel = WADDR_CNT_M1;
        c.wdata_sel = WD_RDATA;
        c.cnt_op    = CNT_INC;
        c.cond      = COND_NOT_COPY_END;
        c.target    = ST_COPY;
      end
      ST_COPY_TAIL: begin
        c.we_sel    = WE_ALWAYS;
        c.waddr_sel = WADDR_CNT_M1;
        c.wdata_sel = WD_RDATA;
      end
      ST_FILL: begin
        c.we_sel    = WE_ALWAYS;
        c.waddr_sel = WADDR_CNT;
        c.wdata_sel = WD_BLANK;
        c.cnt_op    = CNT_INC;
        c.cond      = COND_NOT_LAST;
        c.target    = ST_FILL;
      end
      ST_PUT_DONE: begin
        c.emit   = EMIT_PUT;
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      ST_READ: begin
        c.raddr_sel = RADDR_INDEX;
      end
      ST_READ_DONE: begin
        c.emit   = EMIT_READ;
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: sv/tccw_ram.sv
// generic single-port-write, registered-read ram
module tccw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/text_console_char_writer.sv
// top level of the text console character writer: microcoded sequencer over a cell ram
//
//  channel   signals                                  direction  handshake
//  -------   ---------------------------------------  ---------  ---------------------------
//  request   start, busy, req_i                       in         taken when start && !busy
//  result    result_valid_o, result_o                 out        one-cycle strobe, no stall
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,   in         written when valid && ready
//            cfg_data_i
//
// a put without scroll steps through dispatch, put check and put done, a read through dispatch,
// read and read done; the result strobe shows in the cycle the block is idle again
// a put that scrolls walks the cell ram through its single write port: a copy pass that moves
// each row below the top up by one row, one tail write and a fill pass that blanks the bottom row
// after reset a clearing pass writes zero to every cell, with busy high;
// configuration writes are taken only while the sequencer is idle and no request is offered
// the receiver cannot stall: result_valid_o is high for exactly one cycle per result
module text_console_char_writer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  tccw_pkg::req_t                      req_i,
  output logic                                result_valid_o,
  output tccw_pkg::result_t                   result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tccw_pkg::COLOR_W-1:0]        cfg_data_i
);

  localparam int unsigned COL_W  = tccw_pkg::COL_W;
  localparam int unsigned ROW_W  = tccw_pkg::ROW_W;
  localparam int unsigned ADDR_W = tccw_pkg::ADDR_W;
  localparam int unsigned DATA_W = tccw_pkg::DATA_W;

  // sequencer
  tccw_pkg::step_e pc_q, pc_d;
  tccw_pkg::ctrl_t ctrl;
  logic            jump;

  // datapath registers
  logic [ADDR_W-1:0]            cnt_q, cnt_d;
  tccw_pkg::req_t               req_q;
  logic [COL_W-1:0]             col_q;
  logic [ROW_W-1:0]             row_q;
  logic                         scroll_q;
  logic [tccw_pkg::COLOR_W-1:0] fg_q, bg_q;
  tccw_pkg::result_t            result_q;
  logic                         result_valid_q;

  // cursor arithmetic
  logic [COL_W:0]   col_w;
  logic [ROW_W:0]   row_w;
  logic             printable;
  logic             scroll;
  logic [ADDR_W-1:0] cursor_addr;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [7:0]        attr;

  logic accept;

  assign ctrl   = tccw_pkg::ucode(pc_q);
  assign busy   = !ctrl.idle;
  assign accept = start && !busy;
  assign attr   = {bg_q, fg_q};

  // ---------------------------------------------------------------------------
  // cursor update for a put: control codes first, then printing, wrap and scroll
  // ---------------------------------------------------------------------------
  assign printable   = req_q.char_code >= tccw_pkg::CHAR_SPACE;
  assign cursor_addr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(tccw_pkg::COLS)) + ADDR_W'(col_q);

  always_comb begin
    col_w = {1'b0, col_q};
    row_w = {1'b0, row_q};
    case (req_q.char_code)
      tccw_pkg::CHAR_BS: begin
        if (col_q != '0) begin
          col_w = col_w - (COL_W + 1)'(1);
        end
      end
      tccw_pkg::CHAR_CR: begin
        col_w = '0;
      end
      tccw_pkg::CHAR_LF: begin
        col_w = '0;
        row_w = row_w + (ROW_W + 1)'(1);
      end
      default: ;
    endcase
    if (printable) begin
      col_w = col_w + (COL_W + 1)'(1);
    end
    // wrap at the row end
    if (col_w >= (COL_W + 1)'(tccw_pkg::COLS)) begin
      col_w = '0;
      row_w = row_w + (ROW_W + 1)'(1);
    end
    // past the last row the screen moves up and the cursor stays on the bottom row
    scroll = row_w >= (ROW_W + 1)'(tccw_pkg::ROWS);
    if (scroll) begin
      row_w = (ROW_W + 1)'(tccw_pkg::ROWS - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // jump conditions and next step
  // ---------------------------------------------------------------------------
  always_comb begin
    case (ctrl.cond)
      tccw_pkg::COND_ALWAYS:       jump = 1'b1;
      tccw_pkg::COND_NOT_LAST:     jump = cnt_q != ADDR_W'(tccw_pkg::CELLS - 1);
      tccw_pkg::COND_NOT_COPY_END:
        jump = cnt_q != ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLS - 1);
      tccw_pkg::COND_NO_START:     jump = !start;
      tccw_pkg::COND_IS_READ:      jump = req_q.cmd == tccw_pkg::CMD_READ;
      tccw_pkg::COND_NO_SCROLL:    jump = !scroll_q;
      default:                     jump = 1'b0;
    endcase
    pc_d = jump ? ctrl.target : tccw_pkg::step_e'(pc_q + 4'd1);
  end

  always_comb begin
    case (ctrl.cnt_op)
      tccw_pkg::CNT_CLEAR: cnt_d = '0;
      tccw_pkg::CNT_INC:   cnt_d = cnt_q + ADDR_W'(1);
      default:             cnt_d = cnt_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // cell ram ports
  // ---------------------------------------------------------------------------
  always_comb begin
    case (ctrl.we_sel)
      tccw_pkg::WE_ALWAYS: ram_we = 1'b1;
      tccw_pkg::WE_PRINT:  ram_we = (req_q.cmd == tccw_pkg::CMD_PUT) && printable;
      tccw_pkg::WE_CNT_NZ: ram_we = cnt_q != '0;
      default:             ram_we = 1'b0;
    endcase

    case (ctrl.waddr_sel)
      tccw_pkg::WADDR_CNT_M1: ram_waddr = cnt_q - ADDR_W'(1);
      tccw_pkg::WADDR_CURSOR: ram_waddr = cursor_addr;
      default:                ram_waddr = cnt_q;
    endcase

    case (ctrl.raddr_sel)
      tccw_pkg::RADDR_INDEX: ram_raddr = req_q.cell_index;
      default:               ram_raddr = cnt_q + ADDR_W'(tccw_pkg::COLS);
    endcase

    case (ctrl.wdata_sel)
      tccw_pkg::WD_CHAR:  ram_wdata = {attr, req_q.char_code};
      tccw_pkg::WD_RDATA: ram_wdata = ram_rdata;
      tccw_pkg::WD_BLANK: ram_wdata = {attr, tccw_pkg::CHAR_SPACE};
      default:            ram_wdata = '0;
    endcase
  end

  tccw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (tccw_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q           <= tccw_pkg::ST_CLEAR;
      cnt_q          <= '0;
      col_q          <= '0;
      row_q          <= '0;
      scroll_q       <= 1'b0;
      fg_q           <= tccw_pkg::COLOR_W'(7);
      bg_q           <= '0;
      result_valid_q <= 1'b0;
    end else begin
      pc_q           <= pc_d;
      cnt_q          <= cnt_d;
      result_valid_q <= ctrl.emit != tccw_pkg::EMIT_NONE;
      if (ctrl.cur_upd && (req_q.cmd == tccw_pkg::CMD_PUT)) begin
        col_q    <= col_w[COL_W-1:0];
        row_q    <= row_w[ROW_W-1:0];
        scroll_q <= scroll;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          tccw_pkg::REG_FG_COLOR: fg_q <= cfg_data_i;
          tccw_pkg::REG_BG_COLOR: bg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    case (ctrl.emit)
      tccw_pkg::EMIT_PUT: begin
        result_q.cursor_col <= col_q;
        result_q.cursor_row <= row_q;
        result_q.cell_data  <= '0;
        result_q.scrolled   <= scroll_q;
      end
      tccw_pkg::EMIT_READ: begin
        result_q.cursor_col <= col_q;
        result_q.cursor_row <= row_q;
        // indexes past the screen read as zero
        result_q.cell_data  <= (req_q.cell_index < ADDR_W'(tccw_pkg::CELLS)) ? ram_rdata : '0;
        result_q.scrolled   <= 1'b0;
      end
      default: ;
    endcase
  end

  // color writes only between requests, so no request sees a color change midway
  assign cfg_ready_o    = ctrl.idle && !start;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
